// ===== hdl/rcd_pkg.sv =====
// Shared types and constants for the rotor cipher decrypt core.
package rcd_pkg;

  localparam int ALPHABET_SIZE = 26;
  localparam int LETTER_W = 5;
  localparam int CHAR_W = 8;

  localparam logic [CHAR_W-1:0] CHAR_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_Z = 8'h5A;
  localparam logic [LETTER_W-1:0] LAST_LETTER = 5'(ALPHABET_SIZE - 1);
  localparam logic [LETTER_W-1:0] ALPHA_N = 5'(ALPHABET_SIZE);

  typedef logic [LETTER_W-1:0] letter_t;

  typedef enum logic {
    MODE_LOAD    = 1'b0,
    MODE_DECRYPT = 1'b1
  } mode_t;

  typedef enum logic [1:0] {
    ROTOR_ONE   = 2'd0,
    ROTOR_TWO   = 2'd1,
    ROTOR_THREE = 2'd2,
    ROTOR_NONE  = 2'd3
  } rotor_sel_t;

  typedef struct packed {
    logic       en;
    rotor_sel_t sel;
    letter_t    pos;
    letter_t    letter;
  } rotor_wr_t;

endpackage

// ===== hdl/rcd_rotor_tables.sv =====
// Three inverse rotor tables and the chained lookup through rotors three, two, one.
module rcd_rotor_tables (
  input  logic              clk,
  input  rcd_pkg::rotor_wr_t wr,
  input  rcd_pkg::letter_t  letter_in,
  output rcd_pkg::letter_t  letter_out
);

  rcd_pkg::letter_t inv_one   [rcd_pkg::ALPHABET_SIZE];
  rcd_pkg::letter_t inv_two   [rcd_pkg::ALPHABET_SIZE];
  rcd_pkg::letter_t inv_three [rcd_pkg::ALPHABET_SIZE];

  logic             wr_ok;
  rcd_pkg::letter_t after_three;
  rcd_pkg::letter_t after_two;

  assign wr_ok = wr.en && (wr.pos < rcd_pkg::ALPHA_N) && (wr.letter < rcd_pkg::ALPHA_N);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      case (wr.sel)
        rcd_pkg::ROTOR_ONE:   inv_one[wr.letter]   <= wr.pos;
        rcd_pkg::ROTOR_TWO:   inv_two[wr.letter]   <= wr.pos;
        rcd_pkg::ROTOR_THREE: inv_three[wr.letter] <= wr.pos;
        default: ;
      endcase
    end
  end

  assign after_three = inv_three[letter_in];
  assign after_two   = inv_two[after_three];
  assign letter_out  = inv_one[after_two];

endmodule

// ===== hdl/rcd_shift.sv =====
// Mod-26 Caesar shift back by base shift plus character position.
module rcd_shift (
  input  rcd_pkg::letter_t letter_in,
  input  logic [4:0]       base_shift,
  input  rcd_pkg::letter_t here,
  output rcd_pkg::letter_t letter_out
);

  rcd_pkg::letter_t base_mod;
  logic [5:0]       shift_sum;
  rcd_pkg::letter_t shift;

  always_comb begin
    base_mod  = (base_shift >= rcd_pkg::ALPHA_N) ? base_shift - rcd_pkg::ALPHA_N : base_shift;
    shift_sum = {1'b0, base_mod} + {1'b0, here};
    shift     = (shift_sum >= {1'b0, rcd_pkg::ALPHA_N}) ?
                5'(shift_sum - {1'b0, rcd_pkg::ALPHA_N}) : shift_sum[4:0];
    if (letter_in >= shift) begin
      letter_out = letter_in - shift;
    end else begin
      letter_out = letter_in + rcd_pkg::ALPHA_N - shift;
    end
  end

endmodule

// ===== hdl/rotor_cipher_decrypt_core.sv =====
// Top level of the rotor cipher decrypt core: input stage, lookup, shift, result register.
//
//  channel | handshake             | payload
//  --------+-----------------------+------------------------------------------------
//  in      | in_valid / in_stall   | mode rotor_select rotor_position rotor_letter
//          |                       | char_in first_of_message
//  out     | out_valid / out_stall | char_out
//  cfg     | cfg_valid / cfg_ready | cfg_data (base_shift)
//
// One beat per cycle while in_stall is low; a decrypt beat goes through the input register, then the result register.
// Input register feeds three table lookups and a mod-26 subtract into the result register.
// Loads write the rotor tables when they leave the input register; they give no output.
// Sync reset clears valids, position and base shift; rotor tables are not cleared.
// in_stall rises only when a decrypt waits in the input register behind a stalled result.
module rotor_cipher_decrypt_core (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       mode,
  input  logic [1:0] rotor_select,
  input  logic [4:0] rotor_position,
  input  logic [4:0] rotor_letter,
  input  logic [7:0] char_in,
  input  logic       first_of_message,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_out,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [4:0] cfg_data
);

  logic             s1_valid;
  rcd_pkg::mode_t   s1_mode;
  logic [1:0]       s1_sel;
  rcd_pkg::letter_t s1_pos;
  rcd_pkg::letter_t s1_letter;
  logic [7:0]       s1_char;
  logic             s1_first;

  logic [4:0]       base_shift;
  rcd_pkg::letter_t char_position;
  rcd_pkg::letter_t char_position_next;

  logic             s1_move;
  logic             s1_is_dec;
  logic             is_upper;
  rcd_pkg::letter_t here;
  rcd_pkg::letter_t rotor_in;
  rcd_pkg::letter_t rotor_out;
  rcd_pkg::letter_t plain;
  logic [7:0]       char_out_next;
  rcd_pkg::rotor_wr_t wr;

  assign cfg_ready = 1'b1;

  assign s1_is_dec = (s1_mode == rcd_pkg::MODE_DECRYPT);
  assign s1_move   = !s1_is_dec || !out_valid || !out_stall;
  assign in_stall  = s1_valid && !s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_mode   <= rcd_pkg::mode_t'(mode);
      s1_sel    <= rotor_select;
      s1_pos    <= rotor_position;
      s1_letter <= rotor_letter;
      s1_char   <= char_in;
      s1_first  <= first_of_message;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_shift <= '0;
    end else if (cfg_valid && cfg_ready) begin
      base_shift <= cfg_data;
    end
  end

  always_comb begin
    wr.en     = s1_valid && !s1_is_dec;
    wr.sel    = rcd_pkg::rotor_sel_t'(s1_sel);
    wr.pos    = s1_pos;
    wr.letter = s1_letter;
  end

  assign is_upper = (s1_char >= rcd_pkg::CHAR_A) && (s1_char <= rcd_pkg::CHAR_Z);
  assign rotor_in = 5'(s1_char - rcd_pkg::CHAR_A);
  assign here     = s1_first ? '0 : char_position;

  rcd_rotor_tables u_tables (
    .clk        (clk),
    .wr         (wr),
    .letter_in  (rotor_in),
    .letter_out (rotor_out)
  );

  rcd_shift u_shift (
    .letter_in  (rotor_out),
    .base_shift (base_shift),
    .here       (here),
    .letter_out (plain)
  );

  assign char_out_next      = is_upper ? (rcd_pkg::CHAR_A + {3'b000, plain}) : s1_char;
  assign char_position_next = (here == rcd_pkg::LAST_LETTER) ? '0 : here + 5'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
    end else if (s1_valid && s1_is_dec && s1_move) begin
      char_position <= char_position_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_is_dec && s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_is_dec && s1_move) begin
      char_out <= char_out_next;
    end
  end

endmodule

// ===== bench/rotor_cipher_decrypt_core_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rotor_cipher_decrypt_core: directed and random beats vs. a predictor.
module rotor_cipher_decrypt_core_test;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 8;
  localparam int RANDOM_BEATS = 400;
  localparam int MAX_PRINTS   = 50;

  typedef struct {
    rcd_pkg::mode_t      mode;
    rcd_pkg::rotor_sel_t sel;
    rcd_pkg::letter_t    pos;
    rcd_pkg::letter_t    letter;
    logic [7:0]          ch;
    logic                first;
  } cipher_beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       mode = 1'b0;
  logic [1:0] rotor_select = '0;
  logic [4:0] rotor_position = '0;
  logic [4:0] rotor_letter = '0;
  logic [7:0] char_in = '0;
  logic       first_of_message = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] char_out;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [4:0] cfg_data = '0;

  // predictor state
  rcd_pkg::letter_t inv_rotor [3][rcd_pkg::ALPHABET_SIZE];
  int         msg_pos = 0;
  int         shift_setting = 0;
  logic [7:0] plain_queue [$];

  int error_count = 0;
  int decrypt_count = 0;
  int load_count = 0;
  int checked_count = 0;
  int cfg_count = 0;
  int cycle_count = 0;
  int stall_left = 0;
  bit full_rate = 1'b0;

  rotor_cipher_decrypt_core u_dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .mode             (mode),
    .rotor_select     (rotor_select),
    .rotor_position   (rotor_position),
    .rotor_letter     (rotor_letter),
    .char_in          (char_in),
    .first_of_message (first_of_message),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .char_out         (char_out),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_count, plain_queue.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic int draw_wait();
    return full_rate ? 0 : $urandom_range(0, 8);
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= MAX_PRINTS)
      $display("[%0t] error: %s", $time, msg);
  endtask

  // Applies one accepted beat to the predictor state; decrypts queue their plaintext.
  function automatic void predict_beat(input cipher_beat_t b);
    int at;
    int idx;
    int shift;
    logic [7:0] plain;
    if (b.mode == rcd_pkg::MODE_LOAD) begin
      if (b.sel != rcd_pkg::ROTOR_NONE && b.pos < rcd_pkg::ALPHABET_SIZE &&
          b.letter < rcd_pkg::ALPHABET_SIZE)
        inv_rotor[int'(b.sel)][b.letter] = b.pos;
      return;
    end
    at = b.first ? 0 : msg_pos;
    plain = b.ch;
    if (b.ch >= rcd_pkg::CHAR_A && b.ch <= rcd_pkg::CHAR_Z) begin
      idx = int'(b.ch - rcd_pkg::CHAR_A);
      idx = inv_rotor[int'(rcd_pkg::ROTOR_THREE)][idx];
      idx = inv_rotor[int'(rcd_pkg::ROTOR_TWO)][idx];
      idx = inv_rotor[int'(rcd_pkg::ROTOR_ONE)][idx];
      shift = (shift_setting % rcd_pkg::ALPHABET_SIZE + at) % rcd_pkg::ALPHABET_SIZE;
      plain = rcd_pkg::CHAR_A +
              8'((idx + rcd_pkg::ALPHABET_SIZE - shift) % rcd_pkg::ALPHABET_SIZE);
    end
    msg_pos = (at + 1) % rcd_pkg::ALPHABET_SIZE;
    plain_queue.push_back(plain);
  endfunction

  function automatic cipher_beat_t load_beat(input int sel, input int pos, input int letter);
    cipher_beat_t b;
    b.mode   = rcd_pkg::MODE_LOAD;
    b.sel    = rcd_pkg::rotor_sel_t'(sel);
    b.pos    = rcd_pkg::letter_t'(pos);
    b.letter = rcd_pkg::letter_t'(letter);
    b.ch     = 8'($urandom_range(0, 255));
    b.first  = 1'($urandom_range(0, 1));
    return b;
  endfunction

  function automatic cipher_beat_t decrypt_beat(input logic [7:0] ch, input logic first);
    cipher_beat_t b;
    b.mode   = rcd_pkg::MODE_DECRYPT;
    b.sel    = rcd_pkg::rotor_sel_t'($urandom_range(0, 3));
    b.pos    = rcd_pkg::letter_t'($urandom_range(0, 31));
    b.letter = rcd_pkg::letter_t'($urandom_range(0, 31));
    b.ch     = ch;
    b.first  = first;
    return b;
  endfunction

  function automatic logic [7:0] any_letter();
    return rcd_pkg::CHAR_A + 8'($urandom_range(0, rcd_pkg::ALPHABET_SIZE - 1));
  endfunction

  function automatic cipher_beat_t random_beat();
    int pick;
    cipher_beat_t b;
    pick = $urandom_range(0, 99);
    if (pick < 60)
      b = decrypt_beat(any_letter(), $urandom_range(0, 19) == 0);
    else if (pick < 75)
      b = decrypt_beat(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
    else if (pick < 95)
      b = load_beat($urandom_range(0, 2), $urandom_range(0, 25), $urandom_range(0, 25));
    else
      b = load_beat($urandom_range(0, 3), $urandom_range(0, 31), $urandom_range(0, 31));
    return b;
  endfunction

  // Valid stays high across back-to-back beats; within this task it only drops for a gap.
  task automatic send_beat(input cipher_beat_t b);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    mode             <= b.mode;
    rotor_select     <= b.sel;
    rotor_position   <= b.pos;
    rotor_letter     <= b.letter;
    char_in          <= b.ch;
    first_of_message <= b.first;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_beat(b);
    if (b.mode == rcd_pkg::MODE_LOAD) load_count++;
    else decrypt_count++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (plain_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_shift(input logic [4:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    shift_setting = value;
    cfg_count++;
  endtask

  // result side: random stall per beat, check against oldest expectation
  always @(posedge clk) begin : result_check
    logic [7:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (plain_queue.size() == 0) begin
        report_error($sformatf("unexpected beat, char_out %02h", char_out));
      end else begin
        want = plain_queue.pop_front();
        checked_count++;
        if (char_out !== want)
          report_error($sformatf("char_out %02h, expected %02h", char_out, want));
      end
      stall_left = draw_wait();
    end else if (stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (stall_left > 0);
  end

  // non-letters must pass through before any rotor is loaded
  task automatic test_passthrough();
    send_beat(decrypt_beat(8'h00, 1'b1));
    send_beat(decrypt_beat(8'hFF, 1'b0));
    send_beat(decrypt_beat(rcd_pkg::CHAR_A - 8'd1, 1'b0));
    send_beat(decrypt_beat(rcd_pkg::CHAR_Z + 8'd1, 1'b0));
    send_beat(decrypt_beat(8'h61, 1'b1));
    send_beat(decrypt_beat(8'h80, 1'b0));
  endtask

  task automatic test_load_rotors();
    int perm [rcd_pkg::ALPHABET_SIZE];
    int j;
    int tmp;
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < rcd_pkg::ALPHABET_SIZE; i++) perm[i] = i;
      for (int i = rcd_pkg::ALPHABET_SIZE - 1; i > 0; i--) begin
        j = $urandom_range(0, i);
        tmp = perm[i];
        perm[i] = perm[j];
        perm[j] = tmp;
      end
      full_rate = (r == 0);
      for (int p = 0; p < rcd_pkg::ALPHABET_SIZE; p++) send_beat(load_beat(r, p, perm[p]));
    end
    full_rate = 1'b0;
  endtask

  task automatic test_letter_edges();
    send_beat(decrypt_beat(rcd_pkg::CHAR_A, 1'b1));
    send_beat(decrypt_beat(rcd_pkg::CHAR_Z, 1'b0));
    // out-of-range loads are dropped
    send_beat(load_beat(rcd_pkg::ROTOR_NONE, 5, 7));
    send_beat(load_beat(rcd_pkg::ROTOR_ONE, 31, 2));
    send_beat(load_beat(rcd_pkg::ROTOR_TWO, 3, 31));
    send_beat(load_beat(rcd_pkg::ROTOR_THREE, 26, 30));
    repeat (4) send_beat(decrypt_beat(any_letter(), 1'b0));
    // same letter loaded twice, last write wins
    send_beat(load_beat(rcd_pkg::ROTOR_THREE, 7, 0));
    send_beat(load_beat(rcd_pkg::ROTOR_THREE, 19, 0));
    send_beat(decrypt_beat(rcd_pkg::CHAR_A, 1'b0));
  endtask

  task automatic test_shift_extremes();
    logic [4:0] settings [4] = '{5'd25, 5'd26, 5'd31, 5'd0};
    foreach (settings[i]) begin
      write_shift(settings[i]);
      send_beat(decrypt_beat(rcd_pkg::CHAR_A, 1'b1));
      send_beat(decrypt_beat(any_letter(), 1'b0));
      send_beat(decrypt_beat(rcd_pkg::CHAR_Z, 1'b0));
    end
  endtask

  // position counter wraps past 25 within one message
  task automatic test_long_message();
    write_shift(5'($urandom_range(0, 31)));
    full_rate = 1'b1;
    for (int i = 0; i < 60; i++) send_beat(decrypt_beat(any_letter(), i == 0));
    full_rate = 1'b0;
  endtask

  task automatic test_random_traffic();
    int sent;
    sent = 0;
    while (sent < RANDOM_BEATS) begin
      write_shift(5'($urandom_range(0, 31)));
      full_rate = ($urandom_range(0, 3) == 0);
      repeat ($urandom_range(40, 120)) begin
        send_beat(random_beat());
        sent++;
      end
    end
    full_rate = 1'b0;
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_passthrough();
    test_load_rotors();
    test_letter_edges();
    test_shift_extremes();
    test_long_message();
    test_random_traffic();
    wait_idle();
    $display("Ran %0d decrypt beats and %0d rotor loads; %0d results checked, %0d errors.",
             decrypt_count, load_count, checked_count, error_count);
    $display("Base shift written %0d times, 0/25/26/31 included.", cfg_count);
    if (error_count == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/rcd_pkg.sv
hdl/rcd_rotor_tables.sv
hdl/rcd_shift.sv
hdl/rotor_cipher_decrypt_core.sv
bench/rotor_cipher_decrypt_core_test.sv
